@@ src/ptia_pkg.sv @@
`default_nettype none
package ptia_pkg;

  // operation codes
  localparam logic [4:0] K_MOV     = 5'd0;
  localparam logic [4:0] K_ADD     = 5'd1;
  localparam logic [4:0] K_SUB     = 5'd2;
  localparam logic [4:0] K_MULLO   = 5'd3;
  localparam logic [4:0] K_MULHI   = 5'd4;
  localparam logic [4:0] K_MULWIDE = 5'd5;
  localparam logic [4:0] K_DIV     = 5'd6;
  localparam logic [4:0] K_REM     = 5'd7;
  localparam logic [4:0] K_MIN     = 5'd8;
  localparam logic [4:0] K_MAX     = 5'd9;
  localparam logic [4:0] K_MADLO   = 5'd10;
  localparam logic [4:0] K_MADHI   = 5'd11;
  localparam logic [4:0] K_MADWIDE = 5'd12;
  localparam logic [4:0] K_NEG     = 5'd13;
  localparam logic [4:0] K_ABS     = 5'd14;
  localparam logic [4:0] K_AND     = 5'd15;
  localparam logic [4:0] K_OR      = 5'd16;
  localparam logic [4:0] K_XOR     = 5'd17;
  localparam logic [4:0] K_NOT     = 5'd18;
  localparam logic [4:0] K_SHL     = 5'd19;
  localparam logic [4:0] K_SHR     = 5'd20;
  localparam logic [4:0] K_SETP    = 5'd21;
  localparam logic [4:0] K_SET     = 5'd22;
  localparam logic [4:0] K_SELP    = 5'd23;
  localparam logic [4:0] K_CVT     = 5'd24;

  // compare codes
  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_LT = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_GT = 3'd4;
  localparam logic [2:0] CMP_GE = 3'd5;

  // size codes
  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;
  localparam logic [1:0] SZ_64 = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_HI64 = 2'd2;

  // restoring divider, one quotient bit per stage
  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  size_code;
    logic        is_signed;
    logic [1:0]  dest_size_code;
    logic [2:0]  compare_code;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [63:0] operand_c;
    logic        select_pred;
  } in_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        pred_result;
    logic [1:0]  error_code;
  } out_t;

  // after operand extension
  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  sc;
    logic        sgn;
    logic [1:0]  dsc;
    logic [2:0]  cmp;
    logic        sel;
    logic [63:0] ra;
    logic [63:0] rb;
    logic [63:0] rc;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } s1_t;

  // result-in-flight bundle, carried to the end
  typedef struct packed {
    logic [63:0] res;
    logic        pred_set;
    logic        pv;
    logic        typed;
    logic [1:0]  err;
    logic        is_div;
    logic        is_rem;
    logic        neg;
    logic [1:0]  sc;
  } tail_t;

  typedef struct packed {
    tail_t       tl;
    logic [4:0]  kind;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] c;
    logic [63:0] rc;
    logic [63:0] p0;
    logic [31:0] p1l;
    logic [31:0] p2l;
  } s2_t;

  typedef struct packed {
    tail_t       tl;
    logic [4:0]  kind;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] c;
    logic [63:0] rc;
    logic [63:0] prod;
  } s3_t;

  typedef struct packed {
    tail_t       tl;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] d;
  } dstg_t;

  function automatic logic [63:0] mask_to(input logic [63:0] v, input logic [1:0] code);
    logic [63:0] m;
    begin
      case (code)
        SZ_8:    m = {56'd0, v[7:0]};
        SZ_16:   m = {48'd0, v[15:0]};
        SZ_32:   m = {32'd0, v[31:0]};
        default: m = v;
      endcase
      return m;
    end
  endfunction

  function automatic logic [63:0] sext_to(input logic [63:0] v, input logic [1:0] code);
    logic [63:0] m;
    begin
      case (code)
        SZ_8:    m = {{56{v[7]}}, v[7:0]};
        SZ_16:   m = {{48{v[15]}}, v[15:0]};
        SZ_32:   m = {{32{v[31]}}, v[31:0]};
        default: m = v;
      endcase
      return m;
    end
  endfunction

endpackage
`default_nettype wire

@@ src/ptia_decode.sv @@
`default_nettype none
module ptia_decode
  import ptia_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire in_t  in_data,
  output logic      s1_valid,
  output s1_t       s1_data
);

  logic s1_valid_r;
  s1_t  s1_data_r;
  s1_t  s1_data_nxt;

  // operand extension by type width
  always_comb begin
    s1_data_nxt.kind = in_data.kind;
    s1_data_nxt.sc   = in_data.size_code;
    s1_data_nxt.sgn  = in_data.is_signed;
    s1_data_nxt.dsc  = in_data.dest_size_code;
    s1_data_nxt.cmp  = in_data.compare_code;
    s1_data_nxt.sel  = in_data.select_pred;
    s1_data_nxt.ra   = in_data.operand_a;
    s1_data_nxt.rb   = in_data.operand_b;
    s1_data_nxt.rc   = in_data.operand_c;
    if (in_data.is_signed) begin
      s1_data_nxt.a = sext_to(in_data.operand_a, in_data.size_code);
      s1_data_nxt.b = sext_to(in_data.operand_b, in_data.size_code);
      s1_data_nxt.c = sext_to(in_data.operand_c, in_data.size_code);
    end else begin
      s1_data_nxt.a = mask_to(in_data.operand_a, in_data.size_code);
      s1_data_nxt.b = mask_to(in_data.operand_b, in_data.size_code);
      s1_data_nxt.c = mask_to(in_data.operand_c, in_data.size_code);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_data_r <= s1_data_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule
`default_nettype wire

@@ src/ptia_exec.sv @@
`default_nettype none
module ptia_exec
  import ptia_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic s1_valid,
  input  wire s1_t  s1_data,
  output logic      s2_valid,
  output s2_t       s2_data
);

  logic s2_valid_r;
  s2_t  s2_data_r;
  s2_t  s2_data_nxt;

  function automatic logic lt(input logic [63:0] x, input logic [63:0] y, input logic sg);
    begin
      if (sg) return {~x[63], x[62:0]} < {~y[63], y[62:0]};
      return x < y;
    end
  endfunction

  // simple ops, error checks, divider operands and multiplier partials
  always_comb begin
    logic [63:0] a, b, ra, rb;
    logic [5:0]  sh;
    logic        cres;
    logic        a_lt_b, b_lt_a;
    a      = s1_data.a;
    b      = s1_data.b;
    ra     = s1_data.ra;
    rb     = s1_data.rb;
    sh     = rb[5:0];
    a_lt_b = lt(a, b, s1_data.sgn);
    b_lt_a = lt(b, a, s1_data.sgn);
    case (s1_data.cmp)
      CMP_EQ:  cres = (a == b);
      CMP_NE:  cres = (a != b);
      CMP_LT:  cres = a_lt_b;
      CMP_LE:  cres = !b_lt_a;
      CMP_GT:  cres = b_lt_a;
      CMP_GE:  cres = !a_lt_b;
      default: cres = 1'b0;
    endcase

    s2_data_nxt.tl.res      = 64'd0;
    s2_data_nxt.tl.pred_set = 1'b0;
    s2_data_nxt.tl.pv       = 1'b0;
    s2_data_nxt.tl.typed    = 1'b1;
    s2_data_nxt.tl.err      = ERR_OK;
    s2_data_nxt.tl.is_div   = 1'b0;
    s2_data_nxt.tl.is_rem   = 1'b0;
    s2_data_nxt.tl.neg      = 1'b0;
    s2_data_nxt.tl.sc       = s1_data.sc;

    case (s1_data.kind)
      K_MOV:     s2_data_nxt.tl.res = ra;
      K_ADD:     s2_data_nxt.tl.res = a + b;
      K_SUB:     s2_data_nxt.tl.res = a - b;
      K_MULLO, K_MADLO: s2_data_nxt.tl.res = 64'd0;
      K_MULHI, K_MADHI: begin
        if (s1_data.sc == SZ_64) s2_data_nxt.tl.err = ERR_HI64;
      end
      K_MULWIDE, K_MADWIDE: s2_data_nxt.tl.typed = 1'b0;
      K_DIV, K_REM: begin
        if (b == 64'd0) begin
          s2_data_nxt.tl.err = ERR_DIV0;
        end else begin
          s2_data_nxt.tl.is_div = 1'b1;
          s2_data_nxt.tl.is_rem = (s1_data.kind == K_REM);
          if (s1_data.kind == K_REM) s2_data_nxt.tl.neg = s1_data.sgn & a[63];
          else s2_data_nxt.tl.neg = s1_data.sgn & (a[63] ^ b[63]);
        end
      end
      K_MIN:     s2_data_nxt.tl.res = b_lt_a ? b : a;
      K_MAX:     s2_data_nxt.tl.res = a_lt_b ? b : a;
      K_NEG:     s2_data_nxt.tl.res = 64'd0 - a;
      K_ABS:     s2_data_nxt.tl.res = a[63] ? (64'd0 - a) : a;
      K_AND:     s2_data_nxt.tl.res = ra & rb;
      K_OR:      s2_data_nxt.tl.res = ra | rb;
      K_XOR:     s2_data_nxt.tl.res = ra ^ rb;
      K_NOT: begin
        s2_data_nxt.tl.res      = ~ra;
        s2_data_nxt.tl.pred_set = 1'b1;
        s2_data_nxt.tl.pv       = (ra == 64'd0);
      end
      K_SHL:     s2_data_nxt.tl.res = mask_to(ra, s1_data.sc) << sh;
      K_SHR: begin
        if (s1_data.sgn) s2_data_nxt.tl.res = 64'($signed(a) >>> sh);
        else s2_data_nxt.tl.res = a >> sh;
      end
      K_SETP: begin
        s2_data_nxt.tl.pred_set = 1'b1;
        s2_data_nxt.tl.pv       = cres;
        s2_data_nxt.tl.typed    = 1'b0;
      end
      K_SET: begin
        s2_data_nxt.tl.pred_set = 1'b1;
        s2_data_nxt.tl.pv       = cres;
        s2_data_nxt.tl.res      = {64{cres}};
      end
      K_SELP:    s2_data_nxt.tl.res = s1_data.sel ? ra : rb;
      K_CVT: begin
        s2_data_nxt.tl.res   = mask_to(a, s1_data.dsc);
        s2_data_nxt.tl.typed = 1'b0;
      end
      default: begin
        s2_data_nxt.tl.typed    = 1'b0;
        s2_data_nxt.tl.pred_set = 1'b1;
      end
    endcase

    s2_data_nxt.kind = s1_data.kind;
    s2_data_nxt.ma   = (s1_data.sgn && a[63]) ? (64'd0 - a) : a;
    s2_data_nxt.mb   = (s1_data.sgn && b[63]) ? (64'd0 - b) : b;
    s2_data_nxt.c    = s1_data.c;
    s2_data_nxt.rc   = s1_data.rc;
    // three 32x32 partials give the low 64 bits of the product
    s2_data_nxt.p0   = 64'(a[31:0]) * 64'(b[31:0]);
    s2_data_nxt.p1l  = a[31:0] * b[63:32];
    s2_data_nxt.p2l  = a[63:32] * b[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_data_r;

endmodule
`default_nettype wire

@@ src/ptia_mul_fin.sv @@
`default_nettype none
module ptia_mul_fin
  import ptia_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  s2_valid,
  input  wire s2_t   s2_data,
  output logic       s4_valid,
  output dstg_t      s4_data
);

  logic  s3_valid_r;
  s3_t   s3_data_r;
  s3_t   s3_data_nxt;
  logic  s4_valid_r;
  dstg_t s4_data_r;
  dstg_t s4_data_nxt;

  // partial product sum
  always_comb begin
    s3_data_nxt.tl   = s2_data.tl;
    s3_data_nxt.kind = s2_data.kind;
    s3_data_nxt.ma   = s2_data.ma;
    s3_data_nxt.mb   = s2_data.mb;
    s3_data_nxt.c    = s2_data.c;
    s3_data_nxt.rc   = s2_data.rc;
    s3_data_nxt.prod = s2_data.p0 + {s2_data.p1l + s2_data.p2l, 32'd0};
  end

  // hi shift, addend, and divider entry
  always_comb begin
    logic [63:0] p, hi;
    p = s3_data_r.prod;
    case (s3_data_r.tl.sc)
      SZ_8:    hi = {{8{p[63]}}, p[63:8]};
      SZ_16:   hi = {{16{p[63]}}, p[63:16]};
      default: hi = {{32{p[63]}}, p[63:32]};
    endcase
    s4_data_nxt.tl = s3_data_r.tl;
    case (s3_data_r.kind)
      K_MULLO, K_MULWIDE: s4_data_nxt.tl.res = p;
      K_MULHI:            s4_data_nxt.tl.res = hi;
      K_MADLO:            s4_data_nxt.tl.res = p + s3_data_r.c;
      K_MADHI:            s4_data_nxt.tl.res = hi + s3_data_r.c;
      K_MADWIDE:          s4_data_nxt.tl.res = p + s3_data_r.rc;
      default:            s4_data_nxt.tl.res = s3_data_r.tl.res;
    endcase
    s4_data_nxt.r = 64'd0;
    s4_data_nxt.q = s3_data_r.ma;
    s4_data_nxt.d = s3_data_r.mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_data_r <= s3_data_nxt;
      s4_data_r <= s4_data_nxt;
    end
  end

  assign s4_valid = s4_valid_r;
  assign s4_data  = s4_data_r;

endmodule
`default_nettype wire

@@ src/ptia_divider.sv @@
`default_nettype none
module ptia_divider
  import ptia_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  in_valid,
  input  wire dstg_t in_data,
  output logic       out_valid,
  output dstg_t      out_data
);

  logic [DIV_STEPS-1:0] v_r;
  dstg_t                st_r   [DIV_STEPS];
  dstg_t                st_nxt [DIV_STEPS];

  // one restoring step per stage: shift in a dividend bit, trial subtract
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    dstg_t       src;
    logic [64:0] t;
    logic [64:0] diff;
    if (k == 0) begin : g_first
      assign src = in_data;
    end else begin : g_next
      assign src = st_r[k-1];
    end
    assign t    = {src.r, src.q[63]};
    assign diff = t - {1'b0, src.d};
    always_comb begin
      st_nxt[k].tl = src.tl;
      st_nxt[k].d  = src.d;
      if (!diff[64]) begin
        st_nxt[k].r = diff[63:0];
        st_nxt[k].q = {src.q[62:0], 1'b1};
      end else begin
        st_nxt[k].r = t[63:0];
        st_nxt[k].q = {src.q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS-1];
  assign out_data  = st_r[DIV_STEPS-1];

endmodule
`default_nettype wire

@@ src/ptx_typed_integer_alu_unit.sv @@
// Typed integer execute unit. Throughput one beat per cycle unless an output
// beat is stalled; the 64-stage restoring divider sets the depth,
// and every operation takes the same fixed path so results leave in order.
// A stalled output beat freezes the whole pipeline in place.
// Synchronous reset clears all valid bits; payload registers are not reset.
`default_nettype none
module ptx_typed_integer_alu_unit
  import ptia_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic  en;
  logic  s1_valid;
  s1_t   s1_data;
  logic  s2_valid;
  s2_t   s2_data;
  logic  s4_valid;
  dstg_t s4_data;
  logic  dv_valid;
  dstg_t dv_data;
  logic  out_valid_r;
  out_t  out_data_r;
  out_t  out_data_nxt;

  // pipeline moves unless a result beat is held
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  ptia_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  ptia_exec u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s2_valid (s2_valid),
    .s2_data  (s2_data)
  );

  ptia_mul_fin u_mul_fin (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .s2_valid (s2_valid),
    .s2_data  (s2_data),
    .s4_valid (s4_valid),
    .s4_data  (s4_data)
  );

  ptia_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_valid),
    .in_data   (s4_data),
    .out_valid (dv_valid),
    .out_data  (dv_data)
  );

  // quotient/remainder sign fix, error zeroing, 32-bit masking, predicate
  always_comb begin
    logic [63:0] r;
    logic        pv;
    if (dv_data.tl.is_div) begin
      r = dv_data.tl.is_rem ? dv_data.r : dv_data.q;
      if (dv_data.tl.neg) r = 64'd0 - r;
    end else begin
      r = dv_data.tl.res;
    end
    pv = dv_data.tl.pv;
    if (dv_data.tl.err != ERR_OK) begin
      r  = 64'd0;
      pv = 1'b0;
    end else begin
      if (dv_data.tl.typed && dv_data.tl.sc == SZ_32) r = {32'd0, r[31:0]};
      if (!dv_data.tl.pred_set) pv = (r != 64'd0);
    end
    out_data_nxt.result_value = r;
    out_data_nxt.pred_result  = pv;
    out_data_nxt.error_code   = dv_data.tl.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
